// ===== rtl/core/egq_pkg.sv =====
// shared types, widths and constants for the epsilon-greedy arm selector
// no dependencies; used by every module of the block
package egq_pkg;

    localparam int NUM_ARMS_DEF = 5;

    localparam int ARM_W    = 3;
    localparam int RATE_W   = 17;
    localparam int LOSS_W   = 17;
    localparam int DRAW_W   = 16;
    localparam int REWARD_W = 19;
    localparam int VALUE_W  = 32;
    localparam int STEP_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W   = 16;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 96;

    // shared scaling unit: operand, product and rounded result widths
    localparam int MUL_A_W   = 36;
    localparam int MUL_P_W   = MUL_A_W + RATE_W + 1;
    localparam int MUL_RES_W = MUL_P_W - FRAC_W;
    localparam int UPD_W     = MUL_RES_W + 1;

    localparam logic [RATE_W-1:0] ONE_Q16 = RATE_W'(65536);

    localparam logic [RATE_W-1:0] INITIAL_EPSILON_RST = RATE_W'(58982);
    localparam logic [RATE_W-1:0] EPSILON_DECAY_RST   = RATE_W'(64225);
    localparam logic [RATE_W-1:0] EPSILON_FLOOR_RST   = RATE_W'(3277);
    localparam logic [RATE_W-1:0] DISCOUNT_RST        = RATE_W'(62259);
    localparam logic [RATE_W-1:0] LEARN_RATE_RST      = RATE_W'(6554);
    localparam logic [ARM_W-1:0]  BONUS_ARM_RST       = ARM_W'(4);
    localparam logic [RATE_W-1:0] BONUS_AMOUNT_RST    = RATE_W'(9830);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_EPSILON = 3'd0,
        CFG_EPSILON_DECAY   = 3'd1,
        CFG_EPSILON_FLOOR   = 3'd2,
        CFG_DISCOUNT        = 3'd3,
        CFG_LEARN_RATE      = 3'd4,
        CFG_BONUS_ARM       = 3'd5,
        CFG_BONUS_AMOUNT    = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_BEST,
        ST_TGT_MUL,
        ST_UPD_MUL,
        ST_EPS_MUL,
        ST_SCAN_PICK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               scan_start;
        logic               wr_en;
        logic [VALUE_W-1:0] wr_data;
    } arm_req_t;

    typedef struct packed {
        logic               scan_done;
        logic [VALUE_W-1:0] best_value;
        logic [VALUE_W-1:0] cap_value;
    } arm_stat_t;

endpackage

// ===== rtl/core/egq_mul.sv =====
// shared scaling unit: signed operand times unsigned Q1.16 rate, rounded half up
// three register stages; depends on egq_pkg
module egq_mul
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [egq_pkg::MUL_A_W-1:0]    a,
    input  logic        [egq_pkg::RATE_W-1:0]     rate,
    output logic                                  done,
    output logic signed [egq_pkg::MUL_RES_W-1:0]  res
);

    localparam logic signed [egq_pkg::MUL_P_W-1:0] ROUND_HALF =
        egq_pkg::MUL_P_W'(32768);

    logic signed [egq_pkg::MUL_A_W-1:0]   a_reg;
    logic        [egq_pkg::RATE_W-1:0]    rate_reg;
    logic signed [egq_pkg::MUL_P_W-1:0]   prod_reg;
    logic signed [egq_pkg::MUL_P_W-1:0]   prod_next;
    logic signed [egq_pkg::MUL_P_W-1:0]   rnd_sum;
    logic signed [egq_pkg::MUL_RES_W-1:0] res_reg;
    logic        [2:0]                    vld_reg;

    assign prod_next = egq_pkg::MUL_P_W'(a_reg) *
                       egq_pkg::MUL_P_W'($signed({1'b0, rate_reg}));
    assign rnd_sum   = prod_reg + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            rate_reg <= rate;
        end
        prod_reg <= prod_next;
        res_reg  <= egq_pkg::MUL_RES_W'(rnd_sum >>> egq_pkg::FRAC_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    assign done = vld_reg[2];
    assign res  = res_reg;

endmodule

// ===== rtl/core/egq_arms.sv =====
// arm value store with one registered read port and a sequential maximum scan
// depends on egq_pkg
module egq_arms
#(
    parameter int NUM_ARMS = egq_pkg::NUM_ARMS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  egq_pkg::arm_req_t             req,
    input  logic [$clog2(NUM_ARMS)-1:0]   arm_idx,
    output egq_pkg::arm_stat_t            stat,
    output logic [$clog2(NUM_ARMS)-1:0]   best_idx
);

    localparam int IDX_W = $clog2(NUM_ARMS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ARMS - 1);

    logic signed [egq_pkg::VALUE_W-1:0] mem [NUM_ARMS];
    logic        [NUM_ARMS-1:0]         valid_reg;

    logic                               scan_reg;
    logic        [IDX_W-1:0]            rd_addr_reg;
    logic                               cmp_reg;
    logic        [IDX_W-1:0]            cmp_idx_reg;
    logic                               rd_valid_reg;
    logic signed [egq_pkg::VALUE_W-1:0] rd_data_reg;
    logic signed [egq_pkg::VALUE_W-1:0] rd_value;
    logic        [IDX_W-1:0]            cap_idx_reg;
    logic                               done_reg;
    logic signed [egq_pkg::VALUE_W-1:0] best_reg;
    logic        [IDX_W-1:0]            best_idx_reg;
    logic signed [egq_pkg::VALUE_W-1:0] cap_reg;

    // entries never written read as zero
    assign rd_value = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[arm_idx] <= $signed(req.wr_data);
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            scan_reg     <= 1'b0;
            rd_addr_reg  <= '0;
            cmp_reg      <= 1'b0;
            cmp_idx_reg  <= '0;
            rd_valid_reg <= 1'b0;
            cap_idx_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[arm_idx] <= 1'b1;
            end
            if (req.scan_start)
            begin
                scan_reg    <= 1'b1;
                rd_addr_reg <= '0;
                cap_idx_reg <= arm_idx;
            end
            else if (scan_reg)
            begin
                scan_reg <= (rd_addr_reg != LAST_IDX);
                if (rd_addr_reg != LAST_IDX)
                begin
                    rd_addr_reg <= rd_addr_reg + IDX_W'(1);
                end
            end
            cmp_reg      <= scan_reg;
            cmp_idx_reg  <= rd_addr_reg;
            rd_valid_reg <= valid_reg[rd_addr_reg];
            done_reg     <= cmp_reg && (cmp_idx_reg == LAST_IDX);
        end
    end

    // strict compare keeps the lowest index among equal maxima
    always_ff @(posedge clk)
    begin
        if (cmp_reg)
        begin
            if ((cmp_idx_reg == '0) || (rd_value > best_reg))
            begin
                best_reg     <= rd_value;
                best_idx_reg <= cmp_idx_reg;
            end
            if (cmp_idx_reg == cap_idx_reg)
            begin
                cap_reg <= rd_value;
            end
        end
    end

    assign stat.scan_done  = done_reg;
    assign stat.best_value = best_reg;
    assign stat.cap_value  = cap_reg;
    assign best_idx        = best_idx_reg;

endmodule

// ===== rtl/core/epsilon_greedy_q_update.sv =====
// Between acceptance of an evaluation word and the load of its result word into the
// output register, the block makes two passes over the arm value store through its
// single read port (one value per cycle plus the read and compare stages) and three
// products through the one shared three-stage scaling unit (discounted best value,
// learning step, epsilon decay). The input is not ready during that time and is ready
// again in the cycle after the load, so no new word is taken before the last result is
// loaded. A finished result waits in the output register while the next word is taken,
// and only a still-unread result stalls the end of the following one. No clearing pass
// is needed after reset.
// top level: sequencer, configuration registers and stream ports; uses egq_pkg,
// egq_mul and egq_arms
module epsilon_greedy_q_update
#(
    parameter int NUM_ARMS = egq_pkg::NUM_ARMS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // loss_frac[16:0], explore_draw[32:17], explore_pick[35:33], zero fill
    input  logic [egq_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // previous_arm[2:0], chosen_arm[5:3], explored[6], reward_value[25:7],
    // updated_value[57:26], epsilon_now[74:58], step_count[90:75], zero fill
    output logic [egq_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_we,
    input  logic [egq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [egq_pkg::RATE_W-1:0]         cfg_data
);

    localparam int IDX_W = $clog2(NUM_ARMS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ARMS - 1);
    localparam int PAD_W = egq_pkg::OUT_DATA_W - (2 * egq_pkg::ARM_W + 1 +
        egq_pkg::REWARD_W + egq_pkg::VALUE_W + egq_pkg::RATE_W + egq_pkg::STEP_W);

    egq_pkg::state_t state_reg;
    egq_pkg::state_t state_next;

    logic [egq_pkg::RATE_W-1:0]   decay_reg;
    logic [egq_pkg::RATE_W-1:0]   floor_reg;
    logic [egq_pkg::RATE_W-1:0]   discount_reg;
    logic [egq_pkg::RATE_W-1:0]   learn_rate_reg;
    logic [egq_pkg::ARM_W-1:0]    bonus_arm_reg;
    logic [egq_pkg::RATE_W-1:0]   bonus_amount_reg;

    logic [egq_pkg::RATE_W-1:0]   epsilon_reg;
    logic [IDX_W-1:0]             current_arm_reg;
    logic [egq_pkg::STEP_W-1:0]   steps_reg;

    logic [egq_pkg::DRAW_W-1:0]   draw_reg;
    logic [egq_pkg::ARM_W-1:0]    pick_reg;
    logic [IDX_W-1:0]             prev_reg;
    logic [egq_pkg::REWARD_W-1:0] reward_reg;
    logic [egq_pkg::VALUE_W-1:0]  updated_reg;
    logic                         explored_reg;
    logic                         m_tvalid_reg;
    logic [egq_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic                         accept;
    logic                         out_free;
    logic [egq_pkg::LOSS_W-1:0]   loss_in;
    logic [egq_pkg::LOSS_W-1:0]   loss_cap;
    logic [egq_pkg::REWARD_W-1:0] reward_next;

    logic                                   mul_start;
    logic signed [egq_pkg::MUL_A_W-1:0]     mul_a;
    logic        [egq_pkg::RATE_W-1:0]      mul_rate;
    logic                                   mul_done;
    logic signed [egq_pkg::MUL_RES_W-1:0]   mul_res;

    egq_pkg::arm_req_t            arm_req;
    egq_pkg::arm_stat_t           arm_stat;
    logic [IDX_W-1:0]             best_idx;

    logic signed [egq_pkg::UPD_W-1:0]   upd_wide;
    logic        [egq_pkg::VALUE_W-1:0] upd_sat;
    logic        [egq_pkg::RATE_W-1:0]  eps_decayed;
    logic        [egq_pkg::RATE_W-1:0]  floor_cap;
    logic        [egq_pkg::RATE_W-1:0]  eps_new;
    logic                               explore_now;
    logic        [IDX_W-1:0]            pick_arm;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign loss_in  = s_tdata[egq_pkg::LOSS_W-1:0];
    assign loss_cap = (loss_in > egq_pkg::ONE_Q16) ? egq_pkg::ONE_Q16 : loss_in;

    // reward = 1 - 2*loss (+ bonus), exact in 19-bit two's complement
    always_comb
    begin
        reward_next = egq_pkg::REWARD_W'(egq_pkg::ONE_Q16) - {1'b0, loss_cap, 1'b0};
        if (int'(bonus_arm_reg) == int'(current_arm_reg))
        begin
            reward_next = reward_next + egq_pkg::REWARD_W'(bonus_amount_reg);
        end
    end

    // saturate the new value to 32 bits
    assign upd_wide = egq_pkg::UPD_W'($signed(arm_stat.cap_value)) +
                      egq_pkg::UPD_W'(mul_res);
    always_comb
    begin
        if ((&upd_wide[egq_pkg::UPD_W-1:egq_pkg::VALUE_W-1]) ||
            (~|upd_wide[egq_pkg::UPD_W-1:egq_pkg::VALUE_W-1]))
        begin
            upd_sat = upd_wide[egq_pkg::VALUE_W-1:0];
        end
        else if (upd_wide[egq_pkg::UPD_W-1])
        begin
            upd_sat = {1'b1, {(egq_pkg::VALUE_W-1){1'b0}}};
        end
        else
        begin
            upd_sat = {1'b0, {(egq_pkg::VALUE_W-1){1'b1}}};
        end
    end

    assign eps_decayed = (mul_res > egq_pkg::MUL_RES_W'(egq_pkg::ONE_Q16)) ?
                         egq_pkg::ONE_Q16 : mul_res[egq_pkg::RATE_W-1:0];
    assign floor_cap   = (floor_reg > egq_pkg::ONE_Q16) ? egq_pkg::ONE_Q16 : floor_reg;
    assign eps_new     = (eps_decayed < floor_cap) ? floor_cap : eps_decayed;

    assign explore_now = ({1'b0, draw_reg} < epsilon_reg);
    assign pick_arm    = (int'(pick_reg) >= NUM_ARMS) ? LAST_IDX : IDX_W'(pick_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            egq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = egq_pkg::ST_SCAN_BEST;
                end
            end
            egq_pkg::ST_SCAN_BEST:
            begin
                if (arm_stat.scan_done)
                begin
                    state_next = egq_pkg::ST_TGT_MUL;
                end
            end
            egq_pkg::ST_TGT_MUL:
            begin
                if (mul_done)
                begin
                    state_next = egq_pkg::ST_UPD_MUL;
                end
            end
            egq_pkg::ST_UPD_MUL:
            begin
                if (mul_done)
                begin
                    state_next = egq_pkg::ST_EPS_MUL;
                end
            end
            egq_pkg::ST_EPS_MUL:
            begin
                if (mul_done)
                begin
                    state_next = egq_pkg::ST_SCAN_PICK;
                end
            end
            egq_pkg::ST_SCAN_PICK:
            begin
                if (arm_stat.scan_done)
                begin
                    state_next = egq_pkg::ST_OUT;
                end
            end
            egq_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = egq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = egq_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs and shared unit operands
    always_comb
    begin
        s_tready           = 1'b0;
        mul_start          = 1'b0;
        mul_a              = '0;
        mul_rate           = '0;
        arm_req.scan_start = 1'b0;
        arm_req.wr_en      = 1'b0;
        arm_req.wr_data    = upd_sat;
        unique case (state_reg)
            egq_pkg::ST_IDLE:
            begin
                s_tready           = 1'b1;
                arm_req.scan_start = s_tvalid;
            end
            egq_pkg::ST_SCAN_BEST:
            begin
                mul_start = arm_stat.scan_done;
                mul_a     = egq_pkg::MUL_A_W'($signed(arm_stat.best_value));
                mul_rate  = discount_reg;
            end
            egq_pkg::ST_TGT_MUL:
            begin
                mul_start = mul_done;
                mul_a     = egq_pkg::MUL_A_W'($signed(reward_reg)) +
                            egq_pkg::MUL_A_W'(mul_res) -
                            egq_pkg::MUL_A_W'($signed(arm_stat.cap_value));
                mul_rate  = learn_rate_reg;
            end
            egq_pkg::ST_UPD_MUL:
            begin
                arm_req.wr_en = mul_done;
                mul_start     = mul_done;
                mul_a         = $signed(egq_pkg::MUL_A_W'(epsilon_reg));
                mul_rate      = decay_reg;
            end
            egq_pkg::ST_EPS_MUL:
            begin
                arm_req.scan_start = mul_done;
            end
            egq_pkg::ST_SCAN_PICK:
            begin
            end
            egq_pkg::ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= egq_pkg::ST_IDLE;
            decay_reg        <= egq_pkg::EPSILON_DECAY_RST;
            floor_reg        <= egq_pkg::EPSILON_FLOOR_RST;
            discount_reg     <= egq_pkg::DISCOUNT_RST;
            learn_rate_reg   <= egq_pkg::LEARN_RATE_RST;
            bonus_arm_reg    <= egq_pkg::BONUS_ARM_RST;
            bonus_amount_reg <= egq_pkg::BONUS_AMOUNT_RST;
            epsilon_reg      <= egq_pkg::INITIAL_EPSILON_RST;
            current_arm_reg  <= '0;
            steps_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (egq_pkg::cfg_idx_t'(cfg_index))
                    egq_pkg::CFG_INITIAL_EPSILON:
                    begin
                        epsilon_reg  <= (cfg_data > egq_pkg::ONE_Q16) ?
                                        egq_pkg::ONE_Q16 : cfg_data;
                    end
                    egq_pkg::CFG_EPSILON_DECAY:  decay_reg        <= cfg_data;
                    egq_pkg::CFG_EPSILON_FLOOR:  floor_reg        <= cfg_data;
                    egq_pkg::CFG_DISCOUNT:       discount_reg     <= cfg_data;
                    egq_pkg::CFG_LEARN_RATE:     learn_rate_reg   <= cfg_data;
                    egq_pkg::CFG_BONUS_ARM:
                    begin
                        bonus_arm_reg <= cfg_data[egq_pkg::ARM_W-1:0];
                    end
                    egq_pkg::CFG_BONUS_AMOUNT:   bonus_amount_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            else if ((state_reg == egq_pkg::ST_EPS_MUL) && mul_done)
            begin
                epsilon_reg <= eps_new;
                if (steps_reg != '1)
                begin
                    steps_reg <= steps_reg + egq_pkg::STEP_W'(1);
                end
            end

            if ((state_reg == egq_pkg::ST_SCAN_PICK) && arm_stat.scan_done)
            begin
                current_arm_reg <= explore_now ? pick_arm : best_idx;
            end

            if ((state_reg == egq_pkg::ST_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            draw_reg   <= s_tdata[egq_pkg::LOSS_W +: egq_pkg::DRAW_W];
            pick_reg   <= s_tdata[egq_pkg::LOSS_W + egq_pkg::DRAW_W +: egq_pkg::ARM_W];
            prev_reg   <= current_arm_reg;
            reward_reg <= reward_next;
        end
        if ((state_reg == egq_pkg::ST_UPD_MUL) && mul_done)
        begin
            updated_reg <= upd_sat;
        end
        if ((state_reg == egq_pkg::ST_SCAN_PICK) && arm_stat.scan_done)
        begin
            explored_reg <= explore_now;
        end
        if ((state_reg == egq_pkg::ST_OUT) && out_free)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, steps_reg, epsilon_reg, updated_reg,
                             reward_reg, explored_reg,
                             egq_pkg::ARM_W'(current_arm_reg),
                             egq_pkg::ARM_W'(prev_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    egq_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .rate  (mul_rate),
        .done  (mul_done),
        .res   (mul_res)
    );

    egq_arms
    #(
        .NUM_ARMS (NUM_ARMS)
    )
    u_arms
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (arm_req),
        .arm_idx  (current_arm_reg),
        .stat     (arm_stat),
        .best_idx (best_idx)
    );

endmodule

// ===== rtl/core/egq_checker.sv =====
// port-level checks for epsilon_greedy_q_update, attached by bind
// depends on egq_pkg and the top level's ports
module egq_checker
#(
    parameter int NUM_ARMS = egq_pkg::NUM_ARMS_DEF
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [egq_pkg::OUT_DATA_W-1:0]     m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after an accepted word");

    // chosen arm is a real arm
    a_chosen_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (NUM_ARMS > 8) || (int'(m_tdata[5:3]) < NUM_ARMS))
        else $error("chosen arm out of range");

    // epsilon never above one
    a_eps_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[74:58] <= egq_pkg::ONE_Q16)
        else $error("epsilon above one");

    // padding bits of a result word stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[egq_pkg::OUT_DATA_W-1:91] == '0)
        else $error("padding bits set in result word");

endmodule

bind epsilon_greedy_q_update egq_checker
#(
    .NUM_ARMS (NUM_ARMS)
)
u_egq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
